// ===== hdl/amct_pkg.sv =====
// types, codes and widths shared by the affine matrix unit
package amct_pkg;

  localparam int unsigned VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_LOAD      = 2'd1,
    OP_COMPOSE   = 2'd2,
    OP_TRANSFORM = 2'd3
  } op_e;

  localparam logic [1:0] LAST_ROW  = 2'd2;
  localparam logic [1:0] LAST_TERM = 2'd3;
  localparam logic [1:0] LAST_COL  = 2'd3;

  typedef struct packed {
    op_e                            operation;
    logic [1:0]                     row_index;
    logic signed [VALUE_WIDTH-1:0]  value0;
    logic signed [VALUE_WIDTH-1:0]  value1;
    logic signed [VALUE_WIDTH-1:0]  value2;
    logic signed [VALUE_WIDTH-1:0]  value3;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  out_x;
    logic signed [VALUE_WIDTH-1:0]  out_y;
    logic signed [VALUE_WIDTH-1:0]  out_z;
    logic signed [VALUE_WIDTH-1:0]  out_w;
    logic                           overflow;
  } out_item_t;

  typedef struct packed {
    logic       take_item;
    logic       do_clear;
    logic       do_load;
    logic       latch_row;
    logic       mac_valid;
    logic       mac_first;
    logic       mac_last;
    logic       publish;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/amct_ctrl.sv =====
// sequencer: steps rows, columns and terms of the dot products
module amct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  amct_pkg::dp_status_t  status_i,
  output amct_pkg::dp_cmd_t     cmd_o
);
  import amct_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ROW      = 3'd2;
  localparam logic [2:0] S_MAC      = 3'd3;
  localparam logic [2:0] S_DRAIN    = 3'd4;
  localparam logic [2:0] S_PUB      = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic [1:0] term_q, term_d;
  logic [1:0] last_col;

  // a transform has one dot product per row, a compose has four
  assign last_col = (status_i.op == OP_COMPOSE) ? LAST_COL : 2'd0;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    term_d     = term_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.row  = row_q;
    cmd_o.col  = col_q;
    cmd_o.term = term_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          row_d           = 2'd0;
          col_d           = 2'd0;
          term_d          = 2'd0;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.op) inside
          OP_CLEAR: begin
            cmd_o.do_clear = 1'b1;
            state_d        = S_IDLE;
          end
          OP_LOAD: begin
            cmd_o.do_load = 1'b1;
            state_d       = S_IDLE;
          end
          OP_COMPOSE, OP_TRANSFORM: begin
            state_d = S_ROW;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ROW: begin
        cmd_o.latch_row = 1'b1;
        state_d         = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_valid = 1'b1;
        cmd_o.mac_first = (term_q == 2'd0);
        cmd_o.mac_last  = (term_q == LAST_TERM);
        term_d          = term_q + 2'd1;
        if (term_q == LAST_TERM) begin
          if (col_q == last_col) begin
            col_d = 2'd0;
            if (row_q == LAST_ROW) begin
              state_d = S_DRAIN;
            end else begin
              row_d   = row_q + 2'd1;
              state_d = S_ROW;
            end
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = (status_i.op == OP_TRANSFORM) ? S_PUB : S_IDLE;
        end
      end
      S_PUB: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= 2'd0;
      col_q   <= 2'd0;
      term_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      term_q  <= term_d;
    end
  end

endmodule

// ===== hdl/amct_dp.sv =====
// datapath: matrices, shared multiply-accumulate, saturation and output word
module amct_dp #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  amct_pkg::in_item_t    in_data_i,
  input  amct_pkg::dp_cmd_t     cmd_i,
  output amct_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output amct_pkg::out_item_t   out_data_o
);
  import amct_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned PW = 2 * VW;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  // 1.0, clamped when it does not fit the word
  localparam logic signed [VW-1:0] UNITY =
    (FRACTION_BITS < VW - 1) ? (VW'(1) << FRACTION_BITS) : VMAX;

  in_item_t              item_q;
  logic signed [VW-1:0]  acc_q  [3][4];
  logic signed [VW-1:0]  stg_q  [3][4];
  logic signed [VW-1:0]  arow_q [4];
  logic signed [VW-1:0]  res_q  [3];
  logic                  cov_q;
  logic                  tsat_q;

  logic signed [VW-1:0]  op_a, op_b, pt_val;
  logic signed [PW-1:0]  prod_q;
  logic                  prod_v_q, prod_first_q, prod_last_q;
  logic [1:0]            prod_row_q, prod_col_q;
  logic signed [SW-1:0]  sum_q, sum_d;
  logic                  sum_v_q;
  logic [1:0]            sum_row_q, sum_col_q;

  logic signed [SW-1:0]  shifted;
  logic                  sat;
  logic signed [VW-1:0]  fin;

  out_item_t             out_q;
  logic                  out_v_q;
  logic                  is_compose;

  assign is_compose = (item_q.operation == OP_COMPOSE);

  // operand selection for the current term
  always_comb begin
    case (cmd_i.term)
      2'd0:    pt_val = item_q.value0;
      2'd1:    pt_val = item_q.value1;
      2'd2:    pt_val = item_q.value2;
      default: pt_val = item_q.value3;
    endcase
    op_a = arow_q[cmd_i.term];
    if (!is_compose) begin
      op_b = pt_val;
    end else if (cmd_i.term != LAST_TERM) begin
      op_b = stg_q[cmd_i.term][cmd_i.col];
    end else begin
      // fixed bottom row of the staging matrix
      op_b = (cmd_i.col == LAST_COL) ? UNITY : '0;
    end
  end

  assign sum_d = prod_first_q ? SW'(prod_q) : sum_q + SW'(prod_q);

  // drop the fraction bits, then clamp to the word
  always_comb begin
    shifted = sum_q >>> FRACTION_BITS;
    sat     = !((&shifted[SW-1:VW-1]) || !(|shifted[SW-1:VW-1]));
    if (sat) begin
      fin = shifted[SW-1] ? VMIN : VMAX;
    end else begin
      fin = shifted[VW-1:0];
    end
  end

  // payload and pipeline data
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.latch_row) begin
      for (int k = 0; k < 4; k++) begin
        arow_q[k] <= acc_q[cmd_i.row][k];
      end
    end
    if (cmd_i.mac_valid) begin
      prod_q       <= op_a * op_b;
      prod_first_q <= cmd_i.mac_first;
      prod_last_q  <= cmd_i.mac_last;
      prod_row_q   <= cmd_i.row;
      prod_col_q   <= cmd_i.col;
    end
    if (prod_v_q) begin
      sum_q     <= sum_d;
      sum_row_q <= prod_row_q;
      sum_col_q <= prod_col_q;
    end
    if (sum_v_q && !is_compose) begin
      res_q[sum_row_q] <= fin;
    end
    if (cmd_i.publish) begin
      out_q.out_x    <= res_q[0];
      out_q.out_y    <= res_q[1];
      out_q.out_z    <= res_q[2];
      out_q.out_w    <= item_q.value3;
      out_q.overflow <= tsat_q | cov_q;
    end
  end

  // matrix state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          acc_q[r][c] <= (r == c) ? UNITY : '0;
          stg_q[r][c] <= (r == c) ? UNITY : '0;
        end
      end
      cov_q    <= 1'b0;
      tsat_q   <= 1'b0;
      prod_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.mac_valid;
      sum_v_q  <= prod_v_q & prod_last_q;
      if (cmd_i.take_item) begin
        tsat_q <= 1'b0;
      end else if (sum_v_q && !is_compose && sat) begin
        tsat_q <= 1'b1;
      end
      if (cmd_i.do_clear) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 4; c++) begin
            acc_q[r][c] <= (r == c) ? UNITY : '0;
          end
        end
        cov_q <= 1'b0;
      end else if (sum_v_q && is_compose) begin
        acc_q[sum_row_q][sum_col_q] <= fin;
        if (sat) begin
          cov_q <= 1'b1;
        end
      end
      // row index three is the fixed bottom row and is not stored
      if (cmd_i.do_load && item_q.row_index <= LAST_ROW) begin
        stg_q[item_q.row_index][0] <= item_q.value0;
        stg_q[item_q.row_index][1] <= item_q.value1;
        stg_q[item_q.row_index][2] <= item_q.value2;
        stg_q[item_q.row_index][3] <= item_q.value3;
      end
      if (cmd_i.publish) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign status_o.op        = item_q.operation;
  assign status_o.pipe_busy = prod_v_q | sum_v_q;
  assign status_o.out_free  = !out_v_q | out_ready_i;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/affine_matrix_compose_and_transform.sv =====
// top level of the affine 4x4 matrix compose and transform unit
//
//   port group   direction  word          handshake
//   in_*         in         in_item_t     in_valid_i / in_ready_o
//   out_*        out        out_item_t    out_valid_o / out_ready_i
//
// clear and load end in the dispatch state; transform and compose step the rows
// and drain the pipeline before the next word is taken; one signed multiplier is
// shared by every dot product, one product per cycle save between rows, in a three-deep pipeline.
// reset puts both matrices at identity and clears the overflow flag.
// a finished transform word sits in the output register while the next word is
// taken; a later transform waits for that register to free up.
module affine_matrix_compose_and_transform #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  amct_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output amct_pkg::out_item_t  out_data_o
);
  import amct_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  amct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  amct_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
